FILE: rtl/lwsl_pkg.sv
// Shared constants and types for the longest window sum block.
`timescale 1ns / 1ps
`default_nettype none

package lwsl_pkg;

  // Window buffer depth and field widths
  localparam int unsigned MaxWindow = 1024;
  localparam int unsigned PtrW      = $clog2(MaxWindow);
  localparam int unsigned CntW      = $clog2(MaxWindow + 1);
  localparam int unsigned ValueW    = 16;
  localparam int unsigned LimitW    = 32;
  localparam int unsigned SumW      = 33;

  // Request from the control logic to the window memory
  typedef struct packed {
    logic              we;
    logic [PtrW-1:0]   addr;
    logic [ValueW-1:0] wdata;
  } mem_req_t;

endpackage : lwsl_pkg

`default_nettype wire

FILE: rtl/lwsl_if.sv
// Valid/ready channel interfaces: input words, result words, configuration.
`timescale 1ns / 1ps
`default_nettype none

interface lwsl_in_if;
  import lwsl_pkg::*;
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] item_value;
  logic              is_last;
  modport source (output valid, item_value, is_last, input ready);
  modport sink   (input valid, item_value, is_last, output ready);
endinterface : lwsl_in_if

interface lwsl_out_if;
  import lwsl_pkg::*;
  logic            valid;
  logic            ready;
  logic [CntW-1:0] best_length;
  logic [CntW-1:0] window_length;
  logic            capped;
  logic            final_result;
  modport source (output valid, best_length, window_length, capped, final_result,
                  input ready);
  modport sink   (input valid, best_length, window_length, capped, final_result,
                  output ready);
endinterface : lwsl_out_if

interface lwsl_cfg_if;
  import lwsl_pkg::*;
  logic              valid;
  logic              ready;
  logic [LimitW-1:0] sum_limit;
  modport source (output valid, sum_limit, input ready);
  modport sink   (input valid, sum_limit, output ready);
endinterface : lwsl_cfg_if

`default_nettype wire

FILE: rtl/lwsl_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lwsl_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule : lwsl_ram

`default_nettype wire

FILE: rtl/lwsl_ctrl.sv
// Window control: read-modify-write sequencer over the window memory.
`timescale 1ns / 1ps
`default_nettype none

module lwsl_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [lwsl_pkg::LimitW-1:0] sum_limit_i,
  lwsl_in_if.sink                        in_i,
  lwsl_out_if.source                     out_o,
  output      lwsl_pkg::mem_req_t        mem_req_o,
  input  wire logic [lwsl_pkg::ValueW-1:0] mem_rdata_i
);
  import lwsl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEPTH,
    S_CHECK,
    S_EVICT
  } state_e;

  state_e            state_q;
  logic [PtrW-1:0]   oldest_q;
  logic [CntW-1:0]   count_q;
  logic [SumW-1:0]   sum_q;
  logic [CntW-1:0]   best_q;
  logic [ValueW-1:0] value_q;
  logic              last_q;
  logic              depth_q;
  logic              sum_ev_q;
  logic              out_valid_q;
  logic [CntW-1:0]   out_best_q;
  logic [CntW-1:0]   out_win_q;
  logic              out_capped_q;
  logic              out_final_q;

  logic              accept;
  logic              full;
  logic [CntW-1:0]   slot_wide;
  logic [PtrW-1:0]   slot;
  logic [PtrW-1:0]   oldest_inc;
  logic              over;
  logic              out_free;
  logic [CntW-1:0]   best_new;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign full       = (count_q == CntW'(MaxWindow));
  assign out_free   = !out_valid_q || out_o.ready;

  // Slot after the newest entry, modulo the buffer depth
  always_comb begin
    slot_wide = CntW'(oldest_q) + count_q;
    if (slot_wide >= CntW'(MaxWindow)) begin
      slot_wide = slot_wide - CntW'(MaxWindow);
    end
    slot = slot_wide[PtrW-1:0];
  end

  assign oldest_inc = (oldest_q == PtrW'(MaxWindow - 1)) ? '0 : oldest_q + PtrW'(1);
  assign over       = (count_q != '0) && (sum_q > SumW'(sum_limit_i));
  assign best_new   = (count_q > best_q) ? count_q : best_q;

  // Memory port: addresses the oldest entry, but for a new word written into the free slot
  always_comb begin
    mem_req_o.we    = 1'b0;
    mem_req_o.addr  = oldest_q;
    mem_req_o.wdata = value_q;
    case (state_q)
      S_IDLE: begin
        if (accept && !full) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.addr  = slot;
          mem_req_o.wdata = in_i.item_value;
        end
      end
      S_DEPTH: begin
        // buffer full: new word replaces the evicted oldest one
        mem_req_o.we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, window state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      oldest_q     <= '0;
      count_q      <= '0;
      sum_q        <= '0;
      best_q       <= '0;
      value_q      <= '0;
      last_q       <= 1'b0;
      depth_q      <= 1'b0;
      sum_ev_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_best_q   <= '0;
      out_win_q    <= '0;
      out_capped_q <= 1'b0;
      out_final_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            value_q  <= in_i.item_value;
            last_q   <= in_i.is_last;
            sum_ev_q <= 1'b0;
            if (full) begin
              depth_q <= 1'b1;
              state_q <= S_DEPTH;
            end else begin
              depth_q <= 1'b0;
              count_q <= count_q + CntW'(1);
              sum_q   <= sum_q + SumW'(in_i.item_value);
              state_q <= S_CHECK;
            end
          end
        end
        S_DEPTH: begin
          sum_q    <= sum_q - SumW'(mem_rdata_i) + SumW'(value_q);
          oldest_q <= oldest_inc;
          state_q  <= S_CHECK;
        end
        S_CHECK: begin
          if (over) begin
            state_q <= S_EVICT;
          end else if (out_free) begin
            out_valid_q  <= 1'b1;
            out_best_q   <= best_new;
            out_win_q    <= count_q;
            out_capped_q <= depth_q && !sum_ev_q;
            out_final_q  <= last_q;
            state_q      <= S_IDLE;
            if (last_q) begin
              oldest_q <= '0;
              count_q  <= '0;
              sum_q    <= '0;
              best_q   <= '0;
            end else begin
              best_q <= best_new;
            end
          end
        end
        S_EVICT: begin
          sum_q    <= sum_q - SumW'(mem_rdata_i);
          oldest_q <= oldest_inc;
          count_q  <= count_q - CntW'(1);
          sum_ev_q <= 1'b1;
          state_q  <= S_CHECK;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.best_length   = out_best_q;
  assign out_o.window_length = out_win_q;
  assign out_o.capped        = out_capped_q;
  assign out_o.final_result  = out_final_q;

endmodule : lwsl_ctrl

`default_nettype wire

FILE: rtl/longest_window_sum_within_limit.sv
// Top level: limit register, window memory and window control.
// Sequence: an accepted word passes a depth step when the buffer is full, an evict step per value
//   dropped by the limit between checks, and a check that loads the result register once it is free.
// Throughput: one word in work at a time, since in_i.ready is high only in idle; the
//   single-port window memory has registered read data.
// Reset: pointers, count, sum, best length and sum_limit clear; window memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module longest_window_sum_within_limit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lwsl_cfg_if.sink   cfg_i,
  lwsl_in_if.sink    in_i,
  lwsl_out_if.source out_o
);
  import lwsl_pkg::*;

  logic [LimitW-1:0] sum_limit_q;
  mem_req_t          mem_req;
  logic [ValueW-1:0] mem_rdata;

  // Configuration register, always writable
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_limit_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      sum_limit_q <= cfg_i.sum_limit;
    end
  end

  lwsl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sum_limit_i (sum_limit_q),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // Circular window buffer
  lwsl_ram #(
    .Width (ValueW),
    .Depth (MaxWindow)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

endmodule : longest_window_sum_within_limit

`default_nettype wire

FILE: dv/longest_window_sum_within_limit_tb.sv
// Testbench for the longest window sum block: directed and random words, checked by a predictor.
`timescale 1ns / 1ps

module longest_window_sum_within_limit_tb;
  import lwsl_pkg::*;

  localparam int unsigned StallLimit = 50000;
  localparam int unsigned DrainGap   = 8;

  typedef struct packed {
    logic [CntW-1:0] best_length;
    logic [CntW-1:0] window_length;
    logic            capped;
    logic            final_result;
  } window_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lwsl_cfg_if cfg_w ();
  lwsl_in_if  in_w ();
  lwsl_out_if out_w ();

  longest_window_sum_within_limit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_w),
    .in_i   (in_w),
    .out_o  (out_w)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state
  logic [ValueW-1:0] win_store [MaxWindow];
  int unsigned       win_oldest;
  int unsigned       win_count;
  longint unsigned   win_sum;
  int unsigned       win_best;
  logic [LimitW-1:0] limit_reg;

  window_result_t    pending_results [$];
  int unsigned       error_count;
  int unsigned       tx_idle_pct;
  int unsigned       rx_idle_pct;
  int unsigned       idle_cycles;

  function automatic void clear_window_state();
    win_oldest = 0;
    win_count  = 0;
    win_sum    = 0;
    win_best   = 0;
  endfunction

  function automatic void drop_oldest();
    win_sum -= win_store[win_oldest];
    win_oldest = (win_oldest + 1) % MaxWindow;
    win_count--;
  endfunction

  // Push one word through the window and return the result it produces
  function automatic window_result_t advance_window(logic [ValueW-1:0] v, logic last);
    window_result_t res;
    bit             depth_drop;
    bit             limit_drop;
    depth_drop = 1'b0;
    limit_drop = 1'b0;
    if (win_count >= MaxWindow) begin
      drop_oldest();
      depth_drop = 1'b1;
    end
    win_store[(win_oldest + win_count) % MaxWindow] = v;
    win_count++;
    win_sum += v;
    while (win_count > 0 && win_sum > limit_reg) begin
      drop_oldest();
      limit_drop = 1'b1;
    end
    if (win_count > win_best) win_best = win_count;
    res.best_length   = win_best[CntW-1:0];
    res.window_length = win_count[CntW-1:0];
    res.capped        = depth_drop && !limit_drop;
    res.final_result  = last;
    if (last) clear_window_state();
    return res;
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Send one word, with random idle cycles ahead of it; predict on acceptance
  task automatic send_word(input logic [ValueW-1:0] v, input logic last);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_w.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_w.valid      <= 1'b1;
    in_w.item_value <= v;
    in_w.is_last    <= last;
    @(posedge clk_i);
    while (!in_w.ready) @(posedge clk_i);
    pending_results.push_back(advance_window(v, last));
  endtask

  // Stop sending and wait until every expected result word has arrived
  task automatic wait_drained();
    in_w.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainGap) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] lim);
    cfg_w.valid     <= 1'b1;
    cfg_w.sum_limit <= lim;
    @(posedge clk_i);
    while (!cfg_w.ready) @(posedge clk_i);
    limit_reg = lim;
    cfg_w.valid <= 1'b0;
  endtask

  function automatic logic [ValueW-1:0] rand_value();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return ValueW'($urandom_range(100));
      5, 6:          return ValueW'($urandom_range(5000));
      7, 8:          return ValueW'($urandom());
      default:       return $urandom_range(1) ? '1 : '0;
    endcase
  endfunction

  function automatic logic [LimitW-1:0] rand_limit();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom();
      3:       return $urandom_range(300);
      4:       return $urandom_range(200000);
      default: return $urandom_range(2000);
    endcase
  endfunction

  // Boundary values, empty windows, exact-limit sums and one-word sequences
  task automatic test_directed();
    wait_drained();
    write_limit(32'd100);
    send_word(16'd0, 1'b0);
    send_word(16'd0, 1'b0);
    send_word(16'hFFFF, 1'b0);   // above limit: window empties
    send_word(16'd30, 1'b0);
    send_word(16'd40, 1'b0);
    send_word(16'd30, 1'b0);     // sum equals limit, kept
    send_word(16'd1, 1'b0);      // one eviction
    send_word(16'd100, 1'b0);    // several evictions in one step
    send_word(16'd0, 1'b1);
    wait_drained();
    write_limit('0);
    send_word(16'd0, 1'b0);
    send_word(16'd1, 1'b0);
    send_word(16'd0, 1'b1);
    wait_drained();
    write_limit('1);
    send_word(16'hFFFF, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'd0, 1'b1);
    send_word(16'd7, 1'b1);      // single-word sequence
    wait_drained();
  endtask

  // Window past the buffer depth: plain capping, then capping plus a limit eviction
  task automatic test_full_buffer();
    wait_drained();
    write_limit('1);
    for (int i = 0; i < MaxWindow + 2; i++) send_word(16'd1000, 1'b0);
    wait_drained();
    write_limit(32'd1024000);    // full window sits exactly at the limit
    send_word(16'd2000, 1'b0);   // depth and limit both evict: not flagged
    send_word(16'd1000, 1'b0);
    send_word(16'd1000, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'd1000, 1'b1);
    wait_drained();
  endtask

  // Random sequences with random limits written between some of them
  task automatic test_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(2) == 0) begin
        wait_drained();
        write_limit(rand_limit());
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 25);
      for (int i = 0; i < len; i++) send_word(rand_value(), i == len - 1);
      sent += len;
    end
    wait_drained();
  endtask

  // Result checker and receiver backpressure
  always @(posedge clk_i) begin
    window_result_t want;
    if (!rst_ni) begin
      out_w.ready <= 1'b0;
    end else begin
      out_w.ready <= ($urandom_range(99) >= rx_idle_pct);
      if (out_w.valid && out_w.ready) begin
        if (pending_results.size() == 0) begin
          report_error("result word with none expected");
        end else begin
          want = pending_results.pop_front();
          if (out_w.best_length !== want.best_length)
            report_error($sformatf("best_length got %0d want %0d",
                                   out_w.best_length, want.best_length));
          if (out_w.window_length !== want.window_length)
            report_error($sformatf("window_length got %0d want %0d",
                                   out_w.window_length, want.window_length));
          if (out_w.capped !== want.capped)
            report_error($sformatf("capped got %b want %b", out_w.capped, want.capped));
          if (out_w.final_result !== want.final_result)
            report_error($sformatf("final_result got %b want %b",
                                   out_w.final_result, want.final_result));
        end
      end
    end
  end

  // Watchdog: cycles without any handshake on the input, result or configuration channel
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_w.valid && in_w.ready) || (out_w.valid && out_w.ready) ||
                 (cfg_w.valid && cfg_w.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    cfg_w.valid     <= 1'b0;
    cfg_w.sum_limit <= '0;
    in_w.valid      <= 1'b0;
    in_w.item_value <= '0;
    in_w.is_last    <= 1'b0;
    error_count = 0;
    limit_reg   = '0;
    clear_window_state();

    // Phase 1: sender idles lightly, receiver heavily
    tx_idle_pct = 34;
    rx_idle_pct = 58;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(120);

    // Phase 2: roles swapped
    tx_idle_pct = 58;
    rx_idle_pct = 34;
    test_full_buffer();
    test_random(120);

    // Phase 3: no idling
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random(120);

    wait_drained();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/lwsl_pkg.sv
rtl/lwsl_if.sv
rtl/lwsl_ram.sv
rtl/lwsl_ctrl.sv
rtl/longest_window_sum_within_limit.sv
dv/longest_window_sum_within_limit_tb.sv
